### hdl/mfsp_pkg.sv
// shared types and constants for the monochrome framebuffer shift/paint unit
package mfsp_pkg;

  typedef enum logic [2:0] {
    OP_PAINT    = 3'd0,
    OP_UP       = 3'd1,
    OP_DOWN     = 3'd2,
    OP_LEFT     = 3'd3,
    OP_RIGHT    = 3'd4,
    OP_CLEAR    = 3'd5,
    OP_READ     = 3'd6,
    OP_READ_ALT = 3'd7
  } op_e_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_RANGE   = 2'd2,
    ST_SPARE   = 2'd3
  } status_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned COL_W  = 8;

  typedef struct packed {
    op_e_t              op;
    logic [COL_W-1:0]   column;
    logic [DATA_W-1:0]  pattern;
  } in_req_t;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  column_data;
  } out_res_t;

  typedef struct packed {
    logic               apply;
    op_e_t              op;
    logic [COL_W-1:0]   column;
    logic [DATA_W-1:0]  pattern;
  } cell_ctrl_t;

endpackage

### hdl/mono_framebuffer_shift_paint_unit.sv
// top level of the monochrome framebuffer shift/paint unit
// Usage:
//   A request enters on in_valid/in_stall with in_req {op, column, pattern}.
//   It is taken at a rising edge with in_valid high and in_stall low.
//   Each request gives exactly one result on out_valid/out_stall carrying
//   out_res {status, column_data}: status 0 done, 1 shift refused, 2 column
//   out of range; column_data is the addressed column after the request.
//   The frame is a row of COLUMNS column cells, each 8*PAGES bits tall;
//   paint writes the addressed cell; clear and all four one-pixel shifts update every cell.
// Sequence:
//   S_IDLE takes the request and registers the blank-edge check over all
//   cells, S_APPLY updates the cells, and S_RESULT reads the addressed column
//   into the result register and raises out_valid once the register is free.
//   A new request is taken only after this three-step sequencer is back in S_IDLE.
// Reset and stall:
//   rst_n (synchronous, active low) clears every column and the sequencer.
//   A stalled result holds in the output register; the next request is still
//   taken and runs up to its read step, where it waits for the register.
module mono_framebuffer_shift_paint_unit import mfsp_pkg::*; #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_res
);

  localparam int unsigned WORD_W = 8 * PAGES;
  localparam int unsigned IDX_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned LOW_W  = (WORD_W < DATA_W) ? WORD_W : DATA_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_RESULT
  } state_t;

  state_t            state_r;
  in_req_t           req_r;
  status_t           status_r;
  logic              refuse_r;
  logic              in_range_r;
  logic              out_valid_r;
  out_res_t          out_res_r;

  logic [WORD_W-1:0] cell_word [COLUMNS];
  cell_ctrl_t        ctrl;
  logic              top_any;
  logic              bot_any;
  logic              first_any;
  logic              last_any;
  logic              in_range;
  logic              refuse;
  status_t           status;
  logic [WORD_W-1:0] rd_word;
  logic [DATA_W-1:0] rd_data;

  assign ctrl.apply   = (state_r == S_APPLY) && !refuse_r;
  assign ctrl.op      = req_r.op;
  assign ctrl.column  = req_r.column;
  assign ctrl.pattern = req_r.pattern;

  for (genvar i = 0; i < COLUMNS; i++) begin : g_cell
    logic [WORD_W-1:0] lw;
    logic [WORD_W-1:0] rw;
    if (i == 0) begin : g_first
      assign lw = '0;
    end else begin : g_mid_l
      assign lw = cell_word[i-1];
    end
    if (i == COLUMNS - 1) begin : g_last
      assign rw = '0;
    end else begin : g_mid_r
      assign rw = cell_word[i+1];
    end
    mfsp_cell #(
      .WORD_W (WORD_W),
      .INDEX  (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_word  (lw),
      .right_word (rw),
      .word       (cell_word[i])
    );
  end

  // edge occupancy over the whole frame
  always_comb begin
    top_any = 1'b0;
    bot_any = 1'b0;
    for (int c = 0; c < COLUMNS; c++) begin
      top_any = top_any | cell_word[c][0];
      bot_any = bot_any | cell_word[c][WORD_W-1];
    end
  end

  assign first_any = |cell_word[0];
  assign last_any  = |cell_word[COLUMNS-1];
  assign in_range  = ({1'b0, in_req.column} < (COL_W + 1)'(COLUMNS));

  always_comb begin
    refuse = 1'b0;
    status = ST_DONE;
    unique case (in_req.op)
      OP_PAINT: begin
        refuse = !in_range;
        status = in_range ? ST_DONE : ST_RANGE;
      end
      OP_UP: begin
        refuse = top_any;
        status = top_any ? ST_REFUSED : ST_DONE;
      end
      OP_DOWN: begin
        refuse = bot_any;
        status = bot_any ? ST_REFUSED : ST_DONE;
      end
      OP_LEFT: begin
        refuse = first_any;
        status = first_any ? ST_REFUSED : ST_DONE;
      end
      OP_RIGHT: begin
        refuse = last_any;
        status = last_any ? ST_REFUSED : ST_DONE;
      end
      OP_CLEAR: begin
        refuse = 1'b0;
        status = ST_DONE;
      end
      OP_READ, OP_READ_ALT: begin
        refuse = 1'b1;
        status = in_range ? ST_DONE : ST_RANGE;
      end
      default: begin
        refuse = 1'b1;
        status = ST_DONE;
      end
    endcase
  end

  assign rd_word = cell_word[req_r.column[IDX_W-1:0]];
  assign rd_data = in_range_r ? DATA_W'(rd_word[LOW_W-1:0]) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      refuse_r    <= 1'b1;
    end else begin
      if (state_r == S_RESULT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r      <= in_req;
            status_r   <= status;
            refuse_r   <= refuse;
            in_range_r <= in_range;
            state_r    <= S_APPLY;
          end
        end
        S_APPLY: begin
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid_r || !out_stall) begin
            out_res_r.status      <= status_r;
            out_res_r.column_data <= rd_data;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### hdl/mfsp_cell.sv
// one framebuffer column: holds its word and trades it with its neighbours
module mfsp_cell import mfsp_pkg::*; #(
  parameter int unsigned WORD_W = 32,
  parameter int unsigned INDEX  = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [WORD_W-1:0] left_word,
  input  logic [WORD_W-1:0] right_word,
  output logic [WORD_W-1:0] word
);

  localparam int unsigned LOW_W = (WORD_W < DATA_W) ? WORD_W : DATA_W;

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic              sel;

  assign sel  = (ctrl.column == COL_W'(INDEX));
  assign word = word_r;

  always_comb begin
    word_nxt = word_r;
    if (ctrl.apply) begin
      case (ctrl.op)
        OP_PAINT: begin
          if (sel) word_nxt = WORD_W'(ctrl.pattern[LOW_W-1:0]);
        end
        OP_UP:    word_nxt = word_r >> 1;
        OP_DOWN:  word_nxt = word_r << 1;
        OP_LEFT:  word_nxt = right_word;
        OP_RIGHT: word_nxt = left_word;
        OP_CLEAR: word_nxt = '0;
        default:  word_nxt = word_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

endmodule
